// File: hdl/ascr_pkg.sv
// ascr_pkg: shared types, side mask codes and arithmetic helpers for the
// box collision resolver. No dependencies; used by every module in hdl.
`timescale 1ns / 1ps
`default_nettype none

package ascr_pkg;

  localparam int CoordWidth = 32;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int WideWidth  = CoordWidth + 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [WideWidth-1:0]  wide_t;
  typedef logic [3:0]                   side_t;

  localparam side_t SideNone   = 4'h0;
  localparam side_t SideTop    = 4'h1;
  localparam side_t SideBottom = 4'h2;
  localparam side_t SideLeft   = 4'h4;
  localparam side_t SideRight  = 4'h8;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } box_t;

  typedef struct packed {
    logic  hit;
    side_t side;
  } contact_t;

  function automatic diff_t sub_coord(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[CoordWidth-1], a};
    eb = {b[CoordWidth-1], b};
    return ea - eb;
  endfunction

  function automatic wide_t widen(coord_t a);
    return {{(WideWidth-CoordWidth){a[CoordWidth-1]}}, a};
  endfunction

  // smaller penetration wins, a tie keeps both axes
  function automatic side_t pick(diff_t h, diff_t v, side_t hs, side_t vs);
    side_t r;
    if (v < h) begin
      r = vs;
    end else if (h < v) begin
      r = hs;
    end else begin
      r = hs | vs;
    end
    return r;
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    wide_t  hi;
    wide_t  lo;
    coord_t r;
    hi = widen({1'b0, {(CoordWidth-1){1'b1}}});
    lo = widen({1'b1, {(CoordWidth-1){1'b0}}});
    if (v > hi) begin
      r = hi[CoordWidth-1:0];
    end else if (v < lo) begin
      r = lo[CoordWidth-1:0];
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/aabb_static_collision_resolver.sv
// Box collision resolver: one moving box against one fixed box, with
// an input register and a result register. Depends on ascr_pkg,
// ascr_classify and ascr_correct.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one request: the
//   moving box now, the moving box before, and the fixed box, as signed
//   Q16.16 corners. The output channel (out_valid_o / out_ready_i)
//   returns one result per request: the contact side mask, the corrected
//   corners and the overlap flag.
//   An accepted request is held in the input register; its result moves
//   into the result register, which drives out_valid_o. Throughput is one
//   request per cycle while the receiver does not stall; the input register
//   feeds the classify and correct logic straight into the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; in_ready_o drops only once
//   both registers are full.
//   Reset clears both valid flags; the block needs no warm-up and accepts
//   a request as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module aabb_static_collision_resolver (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ascr_pkg::coord_t     mover_left_i,
  input  ascr_pkg::coord_t     mover_top_i,
  input  ascr_pkg::coord_t     mover_right_i,
  input  ascr_pkg::coord_t     mover_bottom_i,
  input  ascr_pkg::coord_t     prior_left_i,
  input  ascr_pkg::coord_t     prior_top_i,
  input  ascr_pkg::coord_t     prior_right_i,
  input  ascr_pkg::coord_t     prior_bottom_i,
  input  ascr_pkg::coord_t     wall_left_i,
  input  ascr_pkg::coord_t     wall_top_i,
  input  ascr_pkg::coord_t     wall_right_i,
  input  ascr_pkg::coord_t     wall_bottom_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ascr_pkg::side_t      contact_side_o,
  output ascr_pkg::coord_t     fixed_left_o,
  output ascr_pkg::coord_t     fixed_top_o,
  output ascr_pkg::coord_t     fixed_right_o,
  output ascr_pkg::coord_t     fixed_bottom_o,
  output logic                 overlapping_o
);

  logic               in_valid_q;
  ascr_pkg::box_t     mover_q, prior_q, wall_q;
  logic               out_valid_q;
  ascr_pkg::side_t    side_q;
  ascr_pkg::box_t     fixed_q;
  logic               hit_q;

  logic               out_load;
  logic               in_load;
  ascr_pkg::contact_t contact;
  ascr_pkg::box_t     fixed_d;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  ascr_classify u_classify (
    .mover_i   (mover_q),
    .prior_i   (prior_q),
    .wall_i    (wall_q),
    .contact_o (contact)
  );

  ascr_correct u_correct (
    .mover_i (mover_q),
    .wall_i  (wall_q),
    .side_i  (contact.side),
    .fixed_o (fixed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      mover_q <= '{left: mover_left_i, top: mover_top_i,
                   right: mover_right_i, bottom: mover_bottom_i};
      prior_q <= '{left: prior_left_i, top: prior_top_i,
                   right: prior_right_i, bottom: prior_bottom_i};
      wall_q  <= '{left: wall_left_i, top: wall_top_i,
                   right: wall_right_i, bottom: wall_bottom_i};
    end
    if (out_load && in_valid_q) begin
      side_q  <= contact.side;
      hit_q   <= contact.hit;
      fixed_q <= fixed_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign contact_side_o = side_q;
  assign fixed_left_o   = fixed_q.left;
  assign fixed_top_o    = fixed_q.top;
  assign fixed_right_o  = fixed_q.right;
  assign fixed_bottom_o = fixed_q.bottom;
  assign overlapping_o  = hit_q;

endmodule

`default_nettype wire

// File: hdl/ascr_classify.sv
// ascr_classify: strict overlap test and choice of contact side from the
// previous position. Depends on ascr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ascr_classify (
  input  ascr_pkg::box_t     mover_i,
  input  ascr_pkg::box_t     prior_i,
  input  ascr_pkg::box_t     wall_i,
  output ascr_pkg::contact_t contact_o
);

  logic              hit;
  ascr_pkg::side_t   side;
  ascr_pkg::diff_t   pen_left;
  ascr_pkg::diff_t   pen_right;
  ascr_pkg::diff_t   pen_top;
  ascr_pkg::diff_t   pen_bottom;

  assign hit = !(wall_i.right <= mover_i.left || mover_i.right <= wall_i.left ||
                 wall_i.top <= mover_i.bottom || mover_i.top <= wall_i.bottom);

  assign pen_left   = ascr_pkg::sub_coord(wall_i.right, mover_i.left);
  assign pen_right  = ascr_pkg::sub_coord(mover_i.right, wall_i.left);
  assign pen_top    = ascr_pkg::sub_coord(mover_i.top, wall_i.bottom);
  assign pen_bottom = ascr_pkg::sub_coord(wall_i.top, mover_i.bottom);

  always_comb begin
    side = ascr_pkg::SideNone;
    if (hit) begin
      if (prior_i.left < wall_i.right && wall_i.left < prior_i.right) begin
        if (prior_i.top <= wall_i.bottom) begin
          side = ascr_pkg::SideTop;
        end else if (wall_i.top <= prior_i.bottom) begin
          side = ascr_pkg::SideBottom;
        end
      end else if (prior_i.bottom < wall_i.top && wall_i.bottom < prior_i.top) begin
        if (prior_i.right <= wall_i.left) begin
          side = ascr_pkg::SideRight;
        end else if (wall_i.right <= prior_i.left) begin
          side = ascr_pkg::SideLeft;
        end
      end else if (prior_i.top <= wall_i.bottom) begin
        if (wall_i.right <= prior_i.left) begin
          side = ascr_pkg::pick(pen_left, pen_top, ascr_pkg::SideLeft, ascr_pkg::SideTop);
        end else if (prior_i.right <= wall_i.left) begin
          side = ascr_pkg::pick(pen_right, pen_top, ascr_pkg::SideRight, ascr_pkg::SideTop);
        end
      end else if (wall_i.top <= prior_i.bottom) begin
        if (wall_i.right <= prior_i.left) begin
          side = ascr_pkg::pick(pen_left, pen_bottom, ascr_pkg::SideLeft,
                                ascr_pkg::SideBottom);
        end else if (prior_i.right <= wall_i.left) begin
          side = ascr_pkg::pick(pen_right, pen_bottom, ascr_pkg::SideRight,
                                ascr_pkg::SideBottom);
        end
      end
    end
  end

  assign contact_o.hit  = hit;
  assign contact_o.side = side;

endmodule

`default_nettype wire

// File: hdl/ascr_correct.sv
// ascr_correct: shifts the moving box flush against the fixed box on the
// chosen sides, saturating each corner. Depends on ascr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ascr_correct (
  input  ascr_pkg::box_t  mover_i,
  input  ascr_pkg::box_t  wall_i,
  input  ascr_pkg::side_t side_i,
  output ascr_pkg::box_t  fixed_o
);

  ascr_pkg::wide_t ml, mt, mr, mb;
  ascr_pkg::wide_t wl, wt, wr, wb;
  ascr_pkg::wide_t nl, nt, nr, nb;

  always_comb begin
    ml = ascr_pkg::widen(mover_i.left);
    mt = ascr_pkg::widen(mover_i.top);
    mr = ascr_pkg::widen(mover_i.right);
    mb = ascr_pkg::widen(mover_i.bottom);
    wl = ascr_pkg::widen(wall_i.left);
    wt = ascr_pkg::widen(wall_i.top);
    wr = ascr_pkg::widen(wall_i.right);
    wb = ascr_pkg::widen(wall_i.bottom);
    nl = ml;
    nt = mt;
    nr = mr;
    nb = mb;
    if ((side_i & ascr_pkg::SideTop) != ascr_pkg::SideNone) begin
      nt = wb;
      nb = mb - mt + wb;
    end
    if ((side_i & ascr_pkg::SideBottom) != ascr_pkg::SideNone) begin
      nt = mt + wt - mb;
      nb = wt;
    end
    if ((side_i & ascr_pkg::SideLeft) != ascr_pkg::SideNone) begin
      nl = wr;
      nr = mr + wr - ml;
    end
    if ((side_i & ascr_pkg::SideRight) != ascr_pkg::SideNone) begin
      nl = ml - mr + wl;
      nr = wl;
    end
  end

  assign fixed_o.left   = ascr_pkg::sat_coord(nl);
  assign fixed_o.top    = ascr_pkg::sat_coord(nt);
  assign fixed_o.right  = ascr_pkg::sat_coord(nr);
  assign fixed_o.bottom = ascr_pkg::sat_coord(nb);

endmodule

`default_nettype wire
